/* design/pra_pkg.sv */
// ----------------------------------------------------------------------------
// pra_pkg
// shared types, constants and helpers of the partition region aligner
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int DIV_BITS        = 64;
    localparam int SECTOR_W        = 48;
    localparam int BLOCK_W         = 17;
    localparam int GRAIN_W         = 32;
    localparam int OFFSET_W        = 31;
    localparam int POLICY_W        = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int GRAIN_FLOOR_LOG2 = 20;
    localparam int LATENCY         = 2 * DIV_BITS + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIMAL_IO   = 2'd1;

    localparam logic [POLICY_W-1:0] POL_ALIGN_END = 2'd0;
    localparam logic [POLICY_W-1:0] POL_KEEP_SIZE = 2'd1;
    localparam logic [POLICY_W-1:0] POL_KEEP_END  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_UNUSED    = 2'd3;

    typedef struct packed {
        logic [SECTOR_W-1:0] start_sector;
        logic [SECTOR_W-1:0] sector_count;
        logic [BLOCK_W-1:0]  block_bytes;
        logic [POLICY_W-1:0] policy;
    } t_req;

    typedef struct packed {
        logic [63:0] new_start;
        logic [63:0] new_length;
        logic        ok;
    } t_res;

    typedef struct packed {
        logic [SECTOR_W-1:0] start_sector;
        logic [SECTOR_W-1:0] sector_count;
        logic [POLICY_W-1:0] policy;
        logic                bs_zero;
    } t_side;

    // grain in bytes: at least 1, doubled until it reaches 1 MiB
    function automatic logic [GRAIN_W-1:0] grain_of(input logic [GRAIN_W-1:0] opt);
        logic [GRAIN_W-1:0]                  g;
        logic [GRAIN_W-1:0]                  res;
        logic [GRAIN_W+GRAIN_FLOOR_LOG2-1:0] w;
        logic                                found;
        g     = (opt == '0) ? GRAIN_W'(1) : opt;
        res   = g;
        found = (g >= (GRAIN_W'(1) << GRAIN_FLOOR_LOG2));
        for (int k = 1; k <= GRAIN_FLOOR_LOG2; k++) begin
            w = {{GRAIN_FLOOR_LOG2{1'b0}}, g} << k;
            if (!found && (w >= ((GRAIN_W+GRAIN_FLOOR_LOG2)'(1) << GRAIN_FLOOR_LOG2))) begin
                res   = w[GRAIN_W-1:0];
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

/* design/pra_div_cell.sv */
// ----------------------------------------------------------------------------
// pra_div_cell
// one restoring division step on two lanes sharing a divisor
// ----------------------------------------------------------------------------
module pra_div_cell #(
    parameter int DW = pra_pkg::BLOCK_W,
    parameter int SW = $bits(pra_pkg::t_side)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [DW-1:0]                 i_div,
    input  logic [DW-1:0]                 i_rem_a,
    input  logic [pra_pkg::DIV_BITS-1:0]  i_dq_a,
    input  logic [DW-1:0]                 i_rem_b,
    input  logic [pra_pkg::DIV_BITS-1:0]  i_dq_b,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [DW-1:0]                 o_div,
    output logic [DW-1:0]                 o_rem_a,
    output logic [pra_pkg::DIV_BITS-1:0]  o_dq_a,
    output logic [DW-1:0]                 o_rem_b,
    output logic [pra_pkg::DIV_BITS-1:0]  o_dq_b,
    output logic [SW-1:0]                 o_side
);
    import pra_pkg::*;

    logic                r_valid;
    logic [DW-1:0]       r_div, r_rem_a, r_rem_b;
    logic [DIV_BITS-1:0] r_dq_a, r_dq_b;
    logic [SW-1:0]       r_side;
    logic [DW:0]         ta, tb;
    logic                ge_a, ge_b;
    logic [DW-1:0]       n_rem_a, n_rem_b;

    always_comb begin
        ta      = {i_rem_a, i_dq_a[DIV_BITS-1]};
        tb      = {i_rem_b, i_dq_b[DIV_BITS-1]};
        ge_a    = (ta >= {1'b0, i_div});
        ge_b    = (tb >= {1'b0, i_div});
        n_rem_a = ge_a ? DW'(ta - {1'b0, i_div}) : ta[DW-1:0];
        n_rem_b = ge_b ? DW'(tb - {1'b0, i_div}) : tb[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div   <= i_div;
        r_rem_a <= n_rem_a;
        r_rem_b <= n_rem_b;
        r_dq_a  <= {i_dq_a[DIV_BITS-2:0], ge_a};
        r_dq_b  <= {i_dq_b[DIV_BITS-2:0], ge_b};
        r_side  <= i_side;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem_a = r_rem_a;
    assign o_rem_b = r_rem_b;
    assign o_dq_a  = r_dq_a;
    assign o_dq_b  = r_dq_b;
    assign o_side  = r_side;

endmodule

/* design/pra_div_chain.sv */
// ----------------------------------------------------------------------------
// pra_div_chain
// row of division cells, one quotient bit per cell, one transfer per cycle
// ----------------------------------------------------------------------------
module pra_div_chain #(
    parameter int DW = pra_pkg::BLOCK_W,
    parameter int SW = $bits(pra_pkg::t_side)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [DW-1:0]                 i_div,
    input  logic [pra_pkg::DIV_BITS-1:0]  i_num_a,
    input  logic [pra_pkg::DIV_BITS-1:0]  i_num_b,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [DW-1:0]                 o_div,
    output logic [pra_pkg::DIV_BITS-1:0]  o_quo_a,
    output logic [DW-1:0]                 o_rem_a,
    output logic [pra_pkg::DIV_BITS-1:0]  o_quo_b,
    output logic [DW-1:0]                 o_rem_b,
    output logic [SW-1:0]                 o_side
);
    import pra_pkg::*;

    logic                valid [0:DIV_BITS];
    logic [DW-1:0]       div   [0:DIV_BITS];
    logic [DW-1:0]       rem_a [0:DIV_BITS];
    logic [DW-1:0]       rem_b [0:DIV_BITS];
    logic [DIV_BITS-1:0] dq_a  [0:DIV_BITS];
    logic [DIV_BITS-1:0] dq_b  [0:DIV_BITS];
    logic [SW-1:0]       side  [0:DIV_BITS];

    assign valid[0] = i_valid;
    assign div[0]   = i_div;
    assign rem_a[0] = '0;
    assign rem_b[0] = '0;
    assign dq_a[0]  = i_num_a;
    assign dq_b[0]  = i_num_b;
    assign side[0]  = i_side;

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
        pra_div_cell #(.DW(DW), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[i]),
            .i_div   (div[i]),
            .i_rem_a (rem_a[i]),
            .i_dq_a  (dq_a[i]),
            .i_rem_b (rem_b[i]),
            .i_dq_b  (dq_b[i]),
            .i_side  (side[i]),
            .o_valid (valid[i+1]),
            .o_div   (div[i+1]),
            .o_rem_a (rem_a[i+1]),
            .o_dq_a  (dq_a[i+1]),
            .o_rem_b (rem_b[i+1]),
            .o_dq_b  (dq_b[i+1]),
            .o_side  (side[i+1])
        );
    end

    assign o_valid = valid[DIV_BITS];
    assign o_div   = div[DIV_BITS];
    assign o_quo_a = dq_a[DIV_BITS];
    assign o_rem_a = rem_a[DIV_BITS];
    assign o_quo_b = dq_b[DIV_BITS];
    assign o_rem_b = rem_b[DIV_BITS];
    assign o_side  = side[DIV_BITS];

endmodule

/* design/partition_region_aligner_core.sv */
// ----------------------------------------------------------------------------
// partition_region_aligner_core
// aligns a block device region to the device I/O grain
// ----------------------------------------------------------------------------
// A request is taken in every cycle (o_busy stays low). Its result is driven on
// o_res with o_res_valid, in request order. The pipeline holds two rows of 64
// single-bit division cells: the first divides offset and grain by the block
// size, the second takes both grain remainders. There are three register stages:
// one between the rows and two after the second. Results cannot be held off.
// Configuration writes are always ready; they are registered and apply to
// requests taken after the write.
module partition_region_aligner_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  pra_pkg::t_req                   i_req,
    output logic                            o_res_valid,
    output pra_pkg::t_res                   o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import pra_pkg::*;

    localparam int SW = $bits(t_side);

    logic [OFFSET_W-1:0] r_offset;
    logic [GRAIN_W-1:0]  r_grain;
    t_side               side_in;
    logic                accept;

    logic                c1_valid;
    logic [BLOCK_W-1:0]  c1_div, c1_rem_a, c1_rem_b;
    logic [63:0]         c1_quo_a, c1_quo_b;
    logic [SW-1:0]       c1_side;
    t_side               c1_s;

    logic                r_p_valid;
    t_side               r_p_side;
    logic [GRAIN_W-1:0]  r_p_g;
    logic [63:0]         r_p_x, r_p_y;

    logic                c2_valid;
    logic [GRAIN_W-1:0]  c2_div, c2_rem_a, c2_rem_b;
    logic [63:0]         c2_quo_a, c2_quo_b;
    logic [SW-1:0]       c2_side;
    t_side               c2_s;
    logic [63:0]         c2_end;

    logic                r_a_valid;
    t_side               r_a_side;
    logic [GRAIN_W-1:0]  r_a_d;
    logic [63:0]         r_a_end, r_a_e;

    logic [63:0]         ns, n_len;
    logic                n_ok;
    logic                r_res_valid;
    t_res                r_res;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_grain  <= GRAIN_W'(1) << GRAIN_FLOOR_LOG2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ALIGN_OFFSET) begin
                r_offset <= i_cfg_data[OFFSET_W-1:0];
            end else if (i_cfg_index == CFG_OPTIMAL_IO) begin
                r_grain <= grain_of(i_cfg_data[GRAIN_W-1:0]);
            end
        end
    end

    always_comb begin
        side_in.start_sector = i_req.start_sector;
        side_in.sector_count = i_req.sector_count;
        side_in.policy       = i_req.policy;
        side_in.bs_zero      = (i_req.block_bytes == '0);
    end

    pra_div_chain #(.DW(BLOCK_W), .SW(SW)) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_div   (i_req.block_bytes),
        .i_num_a ({{(64-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset}),
        .i_num_b ({{(64-GRAIN_W){1'b0}}, r_grain}),
        .i_side  (side_in),
        .o_valid (c1_valid),
        .o_div   (c1_div),
        .o_quo_a (c1_quo_a),
        .o_rem_a (c1_rem_a),
        .o_quo_b (c1_quo_b),
        .o_rem_b (c1_rem_b),
        .o_side  (c1_side)
    );

    assign c1_s = t_side'(c1_side);

    // offset removed before snapping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_side <= c1_s;
        r_p_g    <= c1_quo_b[GRAIN_W-1:0];
        r_p_x    <= 64'(c1_s.start_sector) - c1_quo_a;
        r_p_y    <= 64'(c1_s.start_sector) + 64'(c1_s.sector_count) - c1_quo_a;
    end

    pra_div_chain #(.DW(GRAIN_W), .SW(SW)) u_div_grain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .i_div   (r_p_g),
        .i_num_a (r_p_x),
        .i_num_b (r_p_y),
        .i_side  (r_p_side),
        .o_valid (c2_valid),
        .o_div   (c2_div),
        .o_quo_a (c2_quo_a),
        .o_rem_a (c2_rem_a),
        .o_quo_b (c2_quo_b),
        .o_rem_b (c2_rem_b),
        .o_side  (c2_side)
    );

    assign c2_s   = t_side'(c2_side);
    assign c2_end = 64'(c2_s.start_sector) + 64'(c2_s.sector_count) - 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side <= c2_s;
        r_a_d    <= (c2_rem_a != '0) ? (c2_div - c2_rem_a) : '0;
        r_a_end  <= c2_end;
        r_a_e    <= c2_end - 64'(c2_rem_b);
    end

    always_comb begin
        ns    = 64'(r_a_side.start_sector) + 64'(r_a_d);
        n_len = '0;
        n_ok  = 1'b1;
        unique case (r_a_side.policy)
            POL_ALIGN_END: begin
                if (r_a_e < ns) begin
                    n_ok = 1'b0;
                end else begin
                    n_len = r_a_e - ns + 64'd1;
                end
            end
            POL_KEEP_SIZE: begin
                n_len = 64'(r_a_side.sector_count);
            end
            POL_KEEP_END: begin
                if (r_a_end < 64'(r_a_d)) begin
                    n_ok = 1'b0;
                end else begin
                    n_len = 64'(r_a_side.sector_count) - 64'(r_a_d);
                end
            end
            POL_UNUSED: begin
                n_len = '0;
            end
        endcase
        if (r_a_side.bs_zero) begin
            n_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.ok         <= n_ok;
        r_res.new_start  <= n_ok ? ns : '0;
        r_res.new_length <= n_ok ? n_len : '0;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* design/pra_checker.sv */
// ----------------------------------------------------------------------------
// pra_checker
// port level checks of the partition region aligner
// ----------------------------------------------------------------------------
module pra_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            o_busy,
    input  pra_pkg::t_req                   i_req,
    input  logic                            o_res_valid,
    input  pra_pkg::t_res                   o_res,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [pra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import pra_pkg::*;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.ok) |-> (o_res.new_start == '0 && o_res.new_length == '0))
        else $error("failed result carries nonzero fields");

    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("result transfer without matching request");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (!o_busy && o_cfg_ready))
        else $error("request or configuration side stalled");

endmodule

bind partition_region_aligner_core pra_checker u_pra_checker (.*);
